// ===== design/sha256_byte_stream_hasher_assert.svh =====
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTH
// Assert that a condition implies another in the same cycle.
`define SHA_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Assert that a condition implies another in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, a, b)
`define SHA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== design/sha_pkg.sv =====
// Shared types, constants and functions of the SHA-256 byte stream hasher.
package sha_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW = 2;

    // Command codes passed from the front end to the hash engine.
    typedef enum logic [1:0] {
        CMD_BYTE = 2'b01,
        CMD_FINISH = 2'b10
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic [7:0] data;
    } qitem_t;

    // Status from the queue to the hash engine.
    typedef struct packed {
        logic valid;
        qitem_t item;
    } qhead_t;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== design/sha_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine.
module sha_front (
    input  logic clk,
    input  logic rst_n,
    input  logic valid,
    output logic stall,
    input  logic kind,
    input  logic [7:0] data_byte,
    input  logic pop,
    output sha_pkg::qhead_t head
);
    import sha_pkg::*;

    qitem_t mem_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QueuePtrW:0] cnt_reg, cnt_next;
    logic push;
    qitem_t item;

    // Classify the incoming item.
    always_comb
    begin
        item.cmd = kind ? CMD_FINISH : CMD_BYTE;
        item.data = data_byte;
    end

    assign stall = (cnt_reg == (QueuePtrW+1)'(QueueDepth));
    assign push = valid && !stall;
    assign head.valid = (cnt_reg != '0);
    assign head.item = mem_reg[rd_reg];

    // Pointer and count updates.
    always_comb
    begin
        wr_next = push ? wr_reg + 1'b1 : wr_reg;
        rd_next = (pop && head.valid) ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop && head.valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= item;
        end
    end
endmodule

// ===== design/sha_engine.sv =====
// Hash engine: packs bytes, pads, and runs the compression one round a cycle.
module sha_engine (
    input  logic clk,
    input  logic rst_n,
    input  sha_pkg::qhead_t head,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output logic [255:0] digest
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0] fill_reg;
    logic [63:0] bits_reg;
    logic [5:0] rnd_reg;
    logic fin_reg;
    logic last_reg;
    logic len_reg;
    logic [31:0] s0, s1, wnew, t1, t2, wcur;
    logic [31:0] e, a;
    logic [1:0] bsel;
    logic [3:0] widx;
    logic [31:0] bval;

    assign wcur = w_reg[0];
    assign e = v_reg[4];
    assign a = v_reg[0];
    assign s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = s1 + w_reg[9] + s0 + w_reg[0];
    assign t1 = v_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + RoundK[rnd_reg] + wcur;
    assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign widx = fill_reg[5:2];
    assign bsel = fill_reg[1:0];
    assign bval = (fin_reg ? ((fill_reg == '0) && last_reg ? 32'h0 : 32'h0)
                           : {24'h0, head.item.data}) << ({3'd3 - {1'b0, bsel}, 3'b000});

    assign pop = (state_reg == ST_IDLE) && head.valid;
    assign out_valid = (state_reg == ST_OUT);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            bits_reg <= '0;
            rnd_reg <= '0;
            fin_reg <= 1'b0;
            last_reg <= 1'b0;
            len_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (head.valid && head.item.cmd == CMD_BYTE)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        bits_reg <= bits_reg + 64'd8;
                        rnd_reg <= '0;
                    end
                    else if (head.valid)
                    begin
                        fin_reg <= 1'b1;
                        last_reg <= 1'b0;
                        len_reg <= 1'b0;
                    end
                end
                ST_PAD:
                begin
                    // The first pad step writes 0x80, the rest write zeros.
                    // The length goes in at byte 55, which closes the last block.
                    fill_reg <= (fill_reg == 6'd55) ? 6'd0 : fill_reg + 6'd1;
                    last_reg <= 1'b1;
                    rnd_reg <= '0;
                    if (fill_reg == 6'd55)
                    begin
                        len_reg <= 1'b1;
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        fin_reg <= 1'b0;
                        fill_reg <= '0;
                        bits_reg <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            h_reg[i] <= InitH[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && head.item.cmd == CMD_BYTE)
                begin
                    state_next = (fill_reg == 6'd63) ? ST_ROUND : ST_IDLE;
                end
                else if (head.valid)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63 || fill_reg == 6'd55)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath: message words and working variables.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && head.item.cmd == CMD_BYTE)
                begin
                    if (bsel == 2'd0)
                    begin
                        w_reg[widx] <= bval;
                    end
                    else
                    begin
                        w_reg[widx] <= w_reg[widx] | bval;
                    end
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd55 && fill_reg != 6'd63)
                begin
                    w_reg[14] <= bits_reg[63:32];
                    w_reg[15] <= bits_reg[31:0];
                end
                if (bsel == 2'd0)
                begin
                    w_reg[widx] <= last_reg ? 32'h0 : 32'h8000_0000;
                end
                else if (!last_reg)
                begin
                    w_reg[widx] <= w_reg[widx] | (32'h80 << ({3'd3 - {1'b0, bsel}, 3'b000}));
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= wnew;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end

    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                     h_reg[4], h_reg[5], h_reg[6], h_reg[7]};
endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// A byte is absorbed while the engine is idle; every 64th byte starts a compression.
// A finish pads the message, then runs one or two compressions.
// The engine takes no bytes while the single shared round unit compresses a block.
// A four-entry queue lets the input run ahead while the engine compresses.
// Reset: asynchronous, active low; state returns to the SHA-256 initial hash.
// Top level of the SHA-256 byte stream hasher.
`include "sha256_byte_stream_hasher_assert.svh"
module sha256_byte_stream_hasher (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic kind,
    input  logic [7:0] data_byte,
    output logic out_valid,
    input  logic out_stall,
    output logic [63:0] digest_bits_255_192,
    output logic [63:0] digest_bits_191_128,
    output logic [63:0] digest_bits_127_64,
    output logic [63:0] digest_bits_63_0
);
    import sha_pkg::*;

    qhead_t head;
    logic pop;
    logic [255:0] digest;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .kind(kind), .data_byte(data_byte), .pop(pop), .head(head)
    );

    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .digest(digest)
    );

    assign digest_bits_255_192 = digest[255:192];
    assign digest_bits_191_128 = digest[191:128];
    assign digest_bits_127_64 = digest[127:64];
    assign digest_bits_63_0 = digest[63:0];

    // A stalled result must keep its digest.
    `SHA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, $stable(digest))
    // The engine only pops a queue head that exists.
    `SHA_ASSERT_IMP(a_pop, clk, rst_n, pop, head.valid)
endmodule

// ===== tb/sha256_byte_stream_hasher_tb.sv =====
// Self-checking testbench of the SHA-256 byte stream hasher.
module sha256_byte_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] mh;
        logic [63:0] ml;
        logic [63:0] lo;
    } digest_t;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       known;
        digest_t    digest;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic kind;
    logic [7:0] data_byte;
    logic out_valid;
    logic out_stall;
    logic [63:0] digest_bits_255_192;
    logic [63:0] digest_bits_191_128;
    logic [63:0] digest_bits_127_64;
    logic [63:0] digest_bits_63_0;

    sha256_byte_stream_hasher dut (.*);

    // Predictor state.
    logic [31:0] blk [16];
    logic [5:0]  fill;
    logic [63:0] msg_bits;
    logic [31:0] chain [8];

    digest_t digest_q [$];
    logic    known_q [$];
    digest_t known_digest_q [$];
    int      errors;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off;

    initial begin
        clk = 1'b0;
        forever
        begin
            #1 clk = 1'b1;
            #1 clk = 1'b0;
        end
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of the held block into the chain.
    task automatic compress_held();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++) w[r] = blk[r];
        for (int r = 16; r < 64; r++)
        begin
            w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        end
        for (int r = 0; r < 8; r++) v[r] = chain[r];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++) chain[r] += v[r];
    endtask

    task automatic place_byte(input int pos, input logic [7:0] b);
        logic [31:0] val;
        val = 32'(b) << ((3 - pos % 4) * 8);
        if (pos % 4 == 0) blk[pos / 4] = val;
        else blk[pos / 4] |= val;
    endtask

    task automatic hasher_reset();
        fill = '0;
        msg_bits = '0;
        for (int i = 0; i < 16; i++) blk[i] = '0;
        for (int i = 0; i < 8; i++) chain[i] = sha_pkg::InitH[i];
    endtask

    // Advance the predictor by one transfer; queue the digest on finish.
    task automatic absorb_item(input logic k, input logic [7:0] b);
        int p;
        digest_t d;
        if (k == KIND_BYTE)
        begin
            place_byte(fill, b);
            msg_bits += 64'd8;
            fill++;
            if (fill == 0) compress_held();
            return;
        end
        p = fill;
        place_byte(p, 8'h80);
        p++;
        if (p > 56)
        begin
            while (p < 64) begin place_byte(p, 8'h00); p++; end
            compress_held();
            p = 0;
        end
        while (p < 56) begin place_byte(p, 8'h00); p++; end
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        compress_held();
        d = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
        digest_q.push_back(d);
        hasher_reset();
    endtask

    // Offer one item and hold it until transferred.
    task automatic send_item(input logic k, input logic [7:0] b, input logic kn,
                             input digest_t kd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            kind <= logic'($urandom);
            data_byte <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        absorb_item(k, b);
        if (k == KIND_FINISH)
        begin
            known_q.push_back(kn);
            known_digest_q.push_back(kd);
        end
    endtask

    task automatic send_message(input int len, input int flavor);
        digest_t none;
        none = '0;
        for (int i = 0; i < len; i++)
        begin
            case (flavor)
                0: send_item(KIND_BYTE, 8'($urandom), 1'b0, none);
                1: send_item(KIND_BYTE, 8'h00, 1'b0, none);
                default: send_item(KIND_BYTE, 8'hff, 1'b0, none);
            endcase
        end
        send_item(KIND_FINISH, 8'($urandom), 1'b0, none);
    endtask

    // Receiver: random stalls, with a long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result check.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
            begin
                $error("digest transfer with no digest pending");
                errors++;
            end
            else
            begin
                digest_t e;
                logic kn;
                digest_t kd;
                e = digest_q.pop_front();
                kn = known_q.pop_front();
                kd = known_digest_q.pop_front();
                if (kn && kd != e)
                begin
                    $error("predictor disagrees with known digest: %h vs %h", e, kd);
                    errors++;
                end
                if (digest_bits_255_192 !== e.hi)
                begin
                    $error("digest_bits_255_192 exp %h got %h", e.hi, digest_bits_255_192);
                    errors++;
                end
                if (digest_bits_191_128 !== e.mh)
                begin
                    $error("digest_bits_191_128 exp %h got %h", e.mh, digest_bits_191_128);
                    errors++;
                end
                if (digest_bits_127_64 !== e.ml)
                begin
                    $error("digest_bits_127_64 exp %h got %h", e.ml, digest_bits_127_64);
                    errors++;
                end
                if (digest_bits_63_0 !== e.lo)
                begin
                    $error("digest_bits_63_0 exp %h got %h", e.lo, digest_bits_63_0);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    stim_row_t rows [$];

    task automatic add_row(input logic k, input logic [7:0] b, input logic kn, input digest_t kd);
        stim_row_t r;
        r.kind = k; r.data = b; r.known = kn; r.digest = kd;
        rows.push_back(r);
    endtask

    initial begin
        int wait_cycles;
        digest_t none;
        none = '0;
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_BYTE;
        data_byte = '0;
        hasher_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty message, "abc", extreme bytes, ignored data on finish.
        add_row(KIND_FINISH, 8'hff, 1'b1,
            256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855);
        add_row(KIND_BYTE, 8'h61, 1'b0, none);
        add_row(KIND_BYTE, 8'h62, 1'b0, none);
        add_row(KIND_BYTE, 8'h63, 1'b0, none);
        add_row(KIND_FINISH, 8'h00, 1'b1,
            256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad);
        add_row(KIND_BYTE, 8'h00, 1'b0, none);
        add_row(KIND_FINISH, 8'h55, 1'b0, none);
        add_row(KIND_BYTE, 8'hff, 1'b0, none);
        add_row(KIND_BYTE, 8'haa, 1'b0, none);
        add_row(KIND_FINISH, 8'haa, 1'b0, none);
        foreach (rows[i]) send_item(rows[i].kind, rows[i].data, rows[i].known, rows[i].digest);

        // Tail lengths around the one- and two-block pad boundary.
        send_message(55, 1);
        send_message(56, 2);
        send_message(63, 0);
        send_message(64, 0);

        // Random messages over the idling phases; lengths mostly short.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 78 : 23) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 78 : 23) : 0;
            for (int m = 0; m < 11; m++)
                send_message(($urandom_range(9) == 0) ? $urandom_range(130)
                                                      : $urandom_range(20), 0);
        end

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int m = 0; m < 8; m++) send_message($urandom_range(20), 0);
            end
        join
        in_valid <= 1'b0;

        // Drain.
        wait_cycles = 0;
        while (digest_q.size() != 0 && wait_cycles < IdleLimit)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && digest_q.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
